[rtl/piq_pkg.sv]
// Shared widths, types and helpers of the point-in-quad test.
package piq_pkg;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [CROSS_W-1:0] t_cross;

    // Edge vectors of one triangle (A,B,C) against query point P
    typedef struct packed {
        t_diff e0x;
        t_diff e0y;
        t_diff e1x;
        t_diff e1y;
        t_diff dpx;
        t_diff dpy;
        t_diff bpx;
        t_diff bpy;
        t_diff cpx;
        t_diff cpy;
    } t_tri_diff;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_sign;

    // Register enables of the difference, product and sign stages
    typedef struct packed {
        logic en_diff;
        logic en_mul;
        logic en_sgn;
    } t_pipe_ctl;

    function automatic logic tri_inside(t_sign sd, t_sign sv, t_sign sw, t_sign su);
        tri_inside = !sd.zero && (sv == sd) && (sw == sd) && (su == sd);
    endfunction

endpackage

[rtl/piq_if.sv]
// Valid/ready channels for query items and test results.
interface piq_in_if import piq_pkg::*;;
    logic   valid;
    logic   ready;
    t_coord point_x;
    t_coord point_y;
    t_coord corner1_x;
    t_coord corner1_y;
    t_coord corner2_x;
    t_coord corner2_y;
    t_coord corner3_x;
    t_coord corner3_y;
    t_coord corner4_x;
    t_coord corner4_y;

    modport source (
        output valid, point_x, point_y, corner1_x, corner1_y, corner2_x, corner2_y,
               corner3_x, corner3_y, corner4_x, corner4_y,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, corner1_x, corner1_y, corner2_x, corner2_y,
               corner3_x, corner3_y, corner4_x, corner4_y,
        output ready
    );
endinterface

interface piq_out_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic in_first_triangle;
    logic in_second_triangle;

    modport source (
        output valid, inside_res, in_first_triangle, in_second_triangle,
        input  ready
    );
    modport sink (
        input  valid, inside_res, in_first_triangle, in_second_triangle,
        output ready
    );
endinterface

[rtl/point_in_quad_test.sv]
// Top level: four-stage point-in-quad pipeline with valid/ready channels.
//
//   channel  dir  transfer carries
//   i_in     in   query point and corners 1..4, signed Q16.8
//   o_out    out  inside_res, in_first_triangle, in_second_triangle
//
// One item enters per cycle when nothing stalls; its result passes the difference,
// product, sign and output registers and leaves from the output register.
// The depth is set by the stages: differences, 25x25 products, product subtract
// and sign, flag combine into the output register.
// Reset clears the stage valid bits only.
// A stage holds while the stage after it is full and held; a bubble closes up.
module point_in_quad_test import piq_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    piq_in_if.sink       i_in,
    piq_out_if.source    o_out
);

    localparam int NUM_TRI   = 2;
    localparam int NUM_CROSS = 4;
    localparam int CR_D = 0;
    localparam int CR_V = 1;
    localparam int CR_W = 2;
    localparam int CR_U = 3;

    logic      r_vld1, r_vld2, r_vld3, r_vld4;
    logic      adv1, adv2, adv3, adv4;
    t_pipe_ctl ctl;

    t_tri_diff diff [NUM_TRI];
    t_sign     sgn  [NUM_TRI][NUM_CROSS];

    logic r_in1, r_in2;
    logic n_in1, n_in2;

    // A stage may load when it is empty or its content moves on
    assign adv4 = !r_vld4 || o_out.ready;
    assign adv3 = !r_vld3 || adv4;
    assign adv2 = !r_vld2 || adv3;
    assign adv1 = !r_vld1 || adv2;

    assign ctl.en_diff = adv1;
    assign ctl.en_mul  = adv2;
    assign ctl.en_sgn  = adv3;

    assign i_in.ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (adv1) r_vld1 <= i_in.valid;
            if (adv2) r_vld2 <= r_vld1;
            if (adv3) r_vld3 <= r_vld2;
            if (adv4) r_vld4 <= r_vld3;
        end
    end

    // Triangle 1 = (C1,C2,C3), triangle 2 = (C1,C3,C4)
    piq_diff u_diff_t1 (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_px   (i_in.point_x),
        .i_py   (i_in.point_y),
        .i_ax   (i_in.corner1_x),
        .i_ay   (i_in.corner1_y),
        .i_bx   (i_in.corner2_x),
        .i_by   (i_in.corner2_y),
        .i_cx   (i_in.corner3_x),
        .i_cy   (i_in.corner3_y),
        .o_diff (diff[0])
    );

    piq_diff u_diff_t2 (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_px   (i_in.point_x),
        .i_py   (i_in.point_y),
        .i_ax   (i_in.corner1_x),
        .i_ay   (i_in.corner1_y),
        .i_bx   (i_in.corner3_x),
        .i_by   (i_in.corner3_y),
        .i_cx   (i_in.corner4_x),
        .i_cy   (i_in.corner4_y),
        .o_diff (diff[1])
    );

    for (genvar t = 0; t < NUM_TRI; t++) begin : g_tri
        // Denominator: e0 x e1
        piq_cross u_cross_d (
            .i_clk (i_clk), .i_ctl (ctl),
            .i_ax (diff[t].e0x), .i_ay (diff[t].e0y),
            .i_bx (diff[t].e1x), .i_by (diff[t].e1y),
            .o_sign (sgn[t][CR_D])
        );
        // v numerator: (P-A) x e1
        piq_cross u_cross_v (
            .i_clk (i_clk), .i_ctl (ctl),
            .i_ax (diff[t].dpx), .i_ay (diff[t].dpy),
            .i_bx (diff[t].e1x), .i_by (diff[t].e1y),
            .o_sign (sgn[t][CR_V])
        );
        // w numerator: e0 x (P-A)
        piq_cross u_cross_w (
            .i_clk (i_clk), .i_ctl (ctl),
            .i_ax (diff[t].e0x), .i_ay (diff[t].e0y),
            .i_bx (diff[t].dpx), .i_by (diff[t].dpy),
            .o_sign (sgn[t][CR_W])
        );
        // u numerator: (B-P) x (C-P)
        piq_cross u_cross_u (
            .i_clk (i_clk), .i_ctl (ctl),
            .i_ax (diff[t].bpx), .i_ay (diff[t].bpy),
            .i_bx (diff[t].cpx), .i_by (diff[t].cpy),
            .o_sign (sgn[t][CR_U])
        );
    end

    assign n_in1 = tri_inside(sgn[0][CR_D], sgn[0][CR_V], sgn[0][CR_W], sgn[0][CR_U]);
    assign n_in2 = tri_inside(sgn[1][CR_D], sgn[1][CR_V], sgn[1][CR_W], sgn[1][CR_U]);

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_in1 <= n_in1;
            r_in2 <= n_in2;
        end
    end

    assign o_out.valid              = r_vld4;
    assign o_out.in_first_triangle  = r_in1;
    assign o_out.in_second_triangle = r_in2;
    assign o_out.inside_res         = r_in1 | r_in2;

`ifndef SYNTHESIS
    a_out_from_stage3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_vld4) |-> $past(r_vld3))
        else $error("output valid rose without an item in stage 3");

    a_stage2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld2 && !adv3) |=> r_vld2)
        else $error("stalled stage 2 item dropped");

    a_stage3_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld3 && !adv4) |=> r_vld3)
        else $error("stalled stage 3 item dropped");

    a_backpressure_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_vld1 && r_vld2 && r_vld3 && r_vld4))
        else $error("input stalled while the pipeline has a bubble");
`endif

endmodule

[rtl/piq_diff.sv]
// First stage: edge and point difference vectors of one triangle.
module piq_diff import piq_pkg::*; (
    input  logic      i_clk,
    input  t_pipe_ctl i_ctl,
    input  t_coord    i_px,
    input  t_coord    i_py,
    input  t_coord    i_ax,
    input  t_coord    i_ay,
    input  t_coord    i_bx,
    input  t_coord    i_by,
    input  t_coord    i_cx,
    input  t_coord    i_cy,
    output t_tri_diff o_diff
);

    t_tri_diff r_diff;
    t_tri_diff n_diff;

    always_comb begin
        n_diff.e0x = DIFF_W'(i_bx) - DIFF_W'(i_ax);
        n_diff.e0y = DIFF_W'(i_by) - DIFF_W'(i_ay);
        n_diff.e1x = DIFF_W'(i_cx) - DIFF_W'(i_ax);
        n_diff.e1y = DIFF_W'(i_cy) - DIFF_W'(i_ay);
        n_diff.dpx = DIFF_W'(i_px) - DIFF_W'(i_ax);
        n_diff.dpy = DIFF_W'(i_py) - DIFF_W'(i_ay);
        n_diff.bpx = DIFF_W'(i_bx) - DIFF_W'(i_px);
        n_diff.bpy = DIFF_W'(i_by) - DIFF_W'(i_py);
        n_diff.cpx = DIFF_W'(i_cx) - DIFF_W'(i_px);
        n_diff.cpy = DIFF_W'(i_cy) - DIFF_W'(i_py);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_diff) begin
            r_diff <= n_diff;
        end
    end

    assign o_diff = r_diff;

endmodule

[rtl/piq_cross.sv]
// Two stages: products of a 2D cross product, then the sign of their difference.
module piq_cross import piq_pkg::*; (
    input  logic      i_clk,
    input  t_pipe_ctl i_ctl,
    input  t_diff     i_ax,
    input  t_diff     i_ay,
    input  t_diff     i_bx,
    input  t_diff     i_by,
    output t_sign     o_sign
);

    t_prod  r_p;
    t_prod  r_q;
    t_cross n_cross;
    t_sign  r_sign;
    t_sign  n_sign;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_p <= PROD_W'(i_ax) * PROD_W'(i_by);
            r_q <= PROD_W'(i_ay) * PROD_W'(i_bx);
        end
    end

    always_comb begin
        n_cross     = CROSS_W'(r_p) - CROSS_W'(r_q);
        n_sign.neg  = n_cross[CROSS_W-1];
        n_sign.zero = (n_cross == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sgn) begin
            r_sign <= n_sign;
        end
    end

    assign o_sign = r_sign;

endmodule
